FILE: hw/rtl/frwl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frwl_pkg: shared definitions for the fair reader-writer lock arbiter
// Sizes, event codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package frwl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CLIENTS     = 16;
    localparam int MAX_GRANTS  = 16;
    localparam int READER_MAX  = 31;

    localparam int ACT_W    = 3;
    localparam int REQ_W    = 4;
    localparam int READER_W = 5;
    localparam int Q_AW     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int CL_W     = $clog2(CLIENTS);
    localparam int GR_W     = $clog2(MAX_GRANTS + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_ORD_READ  = 3'd0,
        ACT_QUICK     = 3'd1,
        ACT_WRITE     = 3'd2,
        ACT_READ_REL  = 3'd3,
        ACT_WRITE_REL = 3'd4
    } t_action;

    typedef struct packed {
        logic accept;
        logic exec;
        logic grant;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic cand;
        logic slot_free;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: hw/rtl/frwl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frwl_if: event and result channels of the lock arbiter
// Valid-ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface frwl_in_if;
    logic                     valid;
    logic                     ready;
    logic [frwl_pkg::ACT_W-1:0] action;
    logic [frwl_pkg::REQ_W-1:0] requester;

    modport source (output valid, output action, output requester, input ready);
    modport sink   (input valid, input action, input requester, output ready);
endinterface

interface frwl_out_if;
    logic                     valid;
    logic                     ready;
    logic                     grant_valid;
    logic [frwl_pkg::REQ_W-1:0] granted_requester;
    logic                     grant_is_write;
    logic                     error;
    logic                     last;

    modport source (output valid, output grant_valid, output granted_requester,
                    output grant_is_write, output error, output last, input ready);
    modport sink   (input valid, input grant_valid, input granted_requester,
                    input grant_is_write, input error, input last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/fair_reader_writer_lock_arbiter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fair_reader_writer_lock_arbiter: reader-writer lock with a fair queue
// Ordered readers and writers are granted in arrival order; quick readers
// wait in a mask and are served first.
// ----------------------------------------------------------------------------
// Each event takes one beat in, is executed in S_EXEC, then gives one result
// per cycle while the output register is free: a status beat followed by up
// to 16 grant beats, the last flagged. The controller walks the quick mask
// and the queue head one grant at a time, and takes a new event only in
// S_IDLE, once the last beat of the previous one is registered. The result
// register lets the next event be taken while the final beat still waits.
module fair_reader_writer_lock_arbiter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    frwl_in_if.sink    i_in,
    frwl_out_if.source o_out
);
    import frwl_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    frwl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    frwl_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_action            (i_in.action),
        .i_requester         (i_in.requester),
        .o_valid             (o_out.valid),
        .i_ready             (o_out.ready),
        .o_grant_valid       (o_out.grant_valid),
        .o_granted_requester (o_out.granted_requester),
        .o_grant_is_write    (o_out.grant_is_write),
        .o_error             (o_out.error),
        .o_last              (o_out.last)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/frwl_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frwl_dp: lock arbiter datapath
// Holds the waiting ring, holder counts and quick-reader mask, applies one
// event, finds one grant per step and feeds the result output register.
// ----------------------------------------------------------------------------
module frwl_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire frwl_pkg::t_dp_cmd          i_cmd,
    output frwl_pkg::t_dp_status            o_status,
    input  wire logic [frwl_pkg::ACT_W-1:0] i_action,
    input  wire logic [frwl_pkg::REQ_W-1:0] i_requester,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic                            o_grant_valid,
    output logic [frwl_pkg::REQ_W-1:0]      o_granted_requester,
    output logic                            o_grant_is_write,
    output logic                            o_error,
    output logic                            o_last
);
    import frwl_pkg::*;

    t_action               r_act;
    logic [REQ_W-1:0]      r_who;
    logic [REQ_W-1:0]      r_q_client [QUEUE_DEPTH];
    logic                  r_q_wr     [QUEUE_DEPTH];
    logic [Q_AW-1:0]       r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [READER_W-1:0]   r_readers, n_readers;
    logic                  r_writer, n_writer;
    logic [CLIENTS-1:0]    r_mask, n_mask;
    logic [GR_W-1:0]       r_grants, n_grants;
    logic                  r_p_gv, n_p_gv, r_p_wr, n_p_wr, r_p_err, n_p_err;
    logic [REQ_W-1:0]      r_p_who, n_p_who;
    logic                  r_o_valid, n_o_valid;
    logic                  r_o_gv, r_o_wr, r_o_err, r_o_last;
    logic [REQ_W-1:0]      r_o_who;
    logic                  push;
    logic                  quick_any, reader_ok, head_wr, head_ok;
    logic [CL_W-1:0]       qidx;
    logic                  slot_free;

    assign slot_free = !r_o_valid || i_ready;
    assign quick_any = |r_mask;
    assign reader_ok = !r_writer && (r_readers != READER_W'(READER_MAX));
    assign head_wr   = r_q_wr[r_head];
    assign head_ok   = head_wr ? (!r_writer && (r_readers == '0)) : reader_ok;

    always_comb begin
        qidx = '0;
        for (int c = CLIENTS - 1; c >= 0; c--) begin
            if (r_mask[c]) begin
                qidx = CL_W'(c);
            end
        end
    end

    assign o_status.slot_free = slot_free;
    assign o_status.cand = (r_grants != GR_W'(MAX_GRANTS)) &&
        (quick_any ? reader_ok : ((r_count != '0) && head_ok));

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_readers = r_readers;
        n_writer  = r_writer;
        n_mask    = r_mask;
        n_grants  = r_grants;
        n_p_gv    = r_p_gv;
        n_p_who   = r_p_who;
        n_p_wr    = r_p_wr;
        n_p_err   = r_p_err;
        n_o_valid = r_o_valid && !i_ready;
        push      = 1'b0;
        if (i_cmd.exec) begin
            n_p_err = 1'b0;
            unique case (r_act)
                ACT_ORD_READ, ACT_WRITE: begin
                    if ((int'(r_who) >= CLIENTS) || (r_count == CNT_W'(QUEUE_DEPTH))) begin
                        n_p_err = 1'b1;
                    end else begin
                        push    = 1'b1;
                        n_count = r_count + 1'b1;
                        n_tail  = (r_tail == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    end
                end
                ACT_QUICK: begin
                    if (int'(r_who) >= CLIENTS) begin
                        n_p_err = 1'b1;
                    end else begin
                        n_mask = r_mask | (CLIENTS'(1) << r_who);
                    end
                end
                ACT_READ_REL: begin
                    if (r_readers == '0) begin
                        n_p_err = 1'b1;
                    end else begin
                        n_readers = r_readers - 1'b1;
                    end
                end
                ACT_WRITE_REL: begin
                    if (!r_writer) begin
                        n_p_err = 1'b1;
                    end else begin
                        n_writer = 1'b0;
                    end
                end
                default: begin
                    n_p_err = 1'b1;
                end
            endcase
            n_p_gv   = 1'b0;
            n_p_who  = '0;
            n_p_wr   = 1'b0;
            n_grants = '0;
        end
        if (i_cmd.grant) begin
            n_o_valid = 1'b1;
            n_grants  = r_grants + 1'b1;
            n_p_gv    = 1'b1;
            n_p_err   = 1'b0;
            if (quick_any) begin
                n_mask[qidx] = 1'b0;
                n_readers    = r_readers + 1'b1;
                n_p_who      = REQ_W'(qidx);
                n_p_wr       = 1'b0;
            end else begin
                n_p_who = r_q_client[r_head];
                n_p_wr  = head_wr;
                n_count = r_count - 1'b1;
                n_head  = (r_head == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                if (head_wr) begin
                    n_writer = 1'b1;
                end else begin
                    n_readers = r_readers + 1'b1;
                end
            end
        end
        if (i_cmd.finish) begin
            n_o_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_readers <= '0;
            r_writer  <= 1'b0;
            r_mask    <= '0;
            r_grants  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_readers <= n_readers;
            r_writer  <= n_writer;
            r_mask    <= n_mask;
            r_grants  <= n_grants;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act <= t_action'(i_action);
            r_who <= i_requester;
        end
        if (push) begin
            r_q_client[r_tail] <= r_who;
            r_q_wr[r_tail]     <= (r_act == ACT_WRITE);
        end
        r_p_gv  <= n_p_gv;
        r_p_who <= n_p_who;
        r_p_wr  <= n_p_wr;
        r_p_err <= n_p_err;
        if (i_cmd.grant || i_cmd.finish) begin
            r_o_gv   <= r_p_gv;
            r_o_who  <= r_p_who;
            r_o_wr   <= r_p_wr;
            r_o_err  <= r_p_err;
            r_o_last <= i_cmd.finish;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_grant_valid       = r_o_gv;
    assign o_granted_requester = r_o_who;
    assign o_grant_is_write    = r_o_wr;
    assign o_error             = r_o_err;
    assign o_last              = r_o_last;

endmodule
`default_nettype wire

FILE: hw/rtl/frwl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frwl_ctrl: lock arbiter controller
// Sequences event intake, event execution and the grant steps that follow.
// ----------------------------------------------------------------------------
module frwl_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output frwl_pkg::t_dp_cmd         o_cmd,
    input  wire frwl_pkg::t_dp_status i_status
);
    import frwl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_STEP = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_STEP;
            end
            S_STEP: begin
                if (i_status.slot_free) begin
                    if (i_status.cand) begin
                        o_cmd.grant = 1'b1;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire
